### src/sensor_frame_sync_auto_baud_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sensor frame synchroniser
// Shared helpers that clock each property on clk and disable it during reset.
// ----------------------------------------------------------------------------
`ifndef SENSOR_FRAME_SYNC_AUTO_BAUD_MACROS_SVH
`define SENSOR_FRAME_SYNC_AUTO_BAUD_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define SFSAB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SFSAB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/sfsab_pkg.sv
// ----------------------------------------------------------------------------
// sfsab_pkg
// Types and constants of the sensor frame synchroniser with baud search.
// ----------------------------------------------------------------------------
package sfsab_pkg;

  // Frame header bytes.
  localparam logic [7:0] HDR_FIRST  = 8'h42;
  localparam logic [7:0] HDR_SECOND = 8'h4D;

  // Frame store layout: two banks of BANK_SPAN bytes.
  localparam int unsigned BANK_SPAN   = 32;
  localparam int unsigned POS_W       = $clog2(BANK_SPAN);
  localparam int unsigned STORE_DEPTH = 2 * BANK_SPAN;
  localparam int unsigned FRAME_BYTES_DEF = 32;

  // Duplicate check: bytes CHK_FIRST..CHK_LAST must equal those CHK_DIST before.
  localparam logic [POS_W-1:0] CHK_FIRST = POS_W'(10);
  localparam logic [POS_W-1:0] CHK_LAST  = POS_W'(15);
  localparam logic [POS_W-1:0] CHK_DIST  = POS_W'(6);
  // Captured reading bytes 5..10 of a frame.
  localparam int unsigned CAP_BYTES = 6;
  localparam int unsigned CAP_W     = $clog2(CAP_BYTES);

  // Register widths.
  localparam int unsigned NOMINAL_W = 17;
  localparam int unsigned STEP_W    = 10;
  localparam int unsigned LIMIT_W   = 14;
  localparam int unsigned STRAY_W   = 8;
  localparam int unsigned CONFIRM_W = 3;
  localparam int unsigned OFFSET_W  = 15;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = NOMINAL_W;

  // Register reset values.
  localparam logic [NOMINAL_W-1:0] NOMINAL_RST = NOMINAL_W'(9600);
  localparam logic [STEP_W-1:0]    STEP_RST    = STEP_W'(100);
  localparam logic [LIMIT_W-1:0]   LIMIT_RST   = LIMIT_W'(4800);
  localparam logic [STRAY_W-1:0]   STRAY_RST   = STRAY_W'(64);
  localparam logic [CONFIRM_W-1:0] CONFIRM_RST = CONFIRM_W'(3);

  // Saturation bounds.
  localparam int OFFSET_MAX = 16383;
  localparam int RATE_MAX   = 131071;

  // Stream widths.
  localparam int unsigned IN_W      = 8;
  localparam int unsigned READING_W = 16;
  localparam int unsigned OUT_BITS  = 3 + NOMINAL_W + 3 * READING_W;
  localparam int unsigned OUT_W     = ((OUT_BITS + 7) / 8) * 8;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_NOMINAL_BAUD = 3'd0,
    REG_BAUD_STEP    = 3'd1,
    REG_OFFSET_LIMIT = 3'd2,
    REG_STRAY_LIMIT  = 3'd3,
    REG_CONFIRM_MAX  = 3'd4
  } cfg_reg_t;

  // Byte handed from the frame-assembly stage to the update stage.
  typedef struct packed {
    logic [7:0]       rx_byte;
    logic [POS_W-1:0] pos;
    logic             wr;
    logic             stray;
    logic             done;
  } s1_item_t;

endpackage

### src/sfsab_ram.sv
// ----------------------------------------------------------------------------
// sfsab_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module sfsab_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/sensor_frame_sync_auto_baud.sv
// ----------------------------------------------------------------------------
// sensor_frame_sync_auto_baud
// Sensor frame synchroniser with duplicate check and baud-rate search.
// ----------------------------------------------------------------------------
// The block accepts one received byte per clock cycle unless the output stalls,
// and returns exactly one result transaction for every byte through the stage
// register and the output register. Bytes are assembled into frames starting
// 0x42 0x4D and written into a two-bank frame RAM; the single read port fetches
// the byte six positions back for the duplicate check and for the readings, one
// byte per transaction, which sets the figure of one byte per cycle. The result
// stage and an output register let a new byte be taken while a result waits.
// ----------------------------------------------------------------------------
module sensor_frame_sync_auto_baud #(
  parameter int unsigned FRAME_BYTES = sfsab_pkg::FRAME_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input stream; tdata: [7:0] rx_byte.
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [sfsab_pkg::IN_W-1:0]     in_tdata,
  // Result stream; tdata: [0] frame_done, [1] frame_ok, [2] baud_change,
  // [19:3] baud_rate, [35:20] pm1_reading, [51:36] pm25_reading,
  // [67:52] pm10_reading, [71:68] zero.
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [sfsab_pkg::OUT_W-1:0]    out_tdata,
  // Configuration write port.
  input  logic                           cfg_we,
  input  logic [sfsab_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [sfsab_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  import sfsab_pkg::*;

  `include "sensor_frame_sync_auto_baud_macros.svh"

  localparam int unsigned ADDR_W = $clog2(STORE_DEPTH);
  localparam logic [POS_W:0] FRAME_END = (POS_W+1)'(FRAME_BYTES);

  // Configuration registers.
  logic [NOMINAL_W-1:0] nominal_r;
  logic [STEP_W-1:0]    step_r;
  logic [LIMIT_W-1:0]   limit_r;
  logic [STRAY_W-1:0]   stray_limit_r;
  logic [CONFIRM_W-1:0] confirm_max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nominal_r     <= NOMINAL_RST;
      step_r        <= STEP_RST;
      limit_r       <= LIMIT_RST;
      stray_limit_r <= STRAY_RST;
      confirm_max_r <= CONFIRM_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_NOMINAL_BAUD: nominal_r     <= cfg_wdata[NOMINAL_W-1:0];
        REG_BAUD_STEP:    step_r        <= cfg_wdata[STEP_W-1:0];
        REG_OFFSET_LIMIT: limit_r       <= cfg_wdata[LIMIT_W-1:0];
        REG_STRAY_LIMIT:  stray_limit_r <= cfg_wdata[STRAY_W-1:0];
        REG_CONFIRM_MAX:  confirm_max_r <= cfg_wdata[CONFIRM_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake and stage control.
  logic     s1_valid_r, s1_valid_nxt;
  s1_item_t s1_r, s1_nxt;
  logic     out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_data_r, out_data_nxt;
  logic     out_free, s1_fire, in_accept;

  assign out_free  = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_accept = in_tvalid && in_tready;

  // Frame assembly: header tracking, position and bank.
  logic [POS_W-1:0] byte_count_r, byte_count_nxt;
  logic             write_bank_r, write_bank_nxt;
  logic [7:0]       rx_byte;
  logic             hdr_go, hdr_drop, s0_wr, s0_done;
  logic [POS_W:0]   cnt_inc;

  assign rx_byte = in_tdata[7:0];

  always_comb begin
    hdr_go   = (byte_count_r != '0) || (rx_byte == HDR_FIRST);
    hdr_drop = (byte_count_r == POS_W'(1)) && (rx_byte != HDR_SECOND);
    s0_wr    = hdr_go && !hdr_drop;
    cnt_inc  = {1'b0, byte_count_r} + (POS_W+1)'(1);
    s0_done  = s0_wr && (cnt_inc >= FRAME_END);
    byte_count_nxt = byte_count_r;
    write_bank_nxt = write_bank_r;
    if (in_accept) begin
      if (hdr_drop || s0_done) begin
        byte_count_nxt = '0;
      end else if (s0_wr) begin
        byte_count_nxt = cnt_inc[POS_W-1:0];
      end
      if (s0_done) begin
        write_bank_nxt = !write_bank_r;
      end
    end
    s1_nxt.rx_byte = rx_byte;
    s1_nxt.pos     = byte_count_r;
    s1_nxt.wr      = s0_wr;
    s1_nxt.stray   = !hdr_go;
    s1_nxt.done    = s0_done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      write_bank_r <= 1'b0;
    end else begin
      byte_count_r <= byte_count_nxt;
      write_bank_r <= write_bank_nxt;
    end
  end

  // Frame RAM: the new byte is written while the byte six places back is read.
  logic [7:0]        rd_data;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;

  assign ram_waddr = {write_bank_r, byte_count_r};
  assign ram_raddr = {write_bank_r, byte_count_r - CHK_DIST};

  sfsab_ram #(
    .WIDTH(8),
    .DEPTH(STORE_DEPTH)
  ) u_frame_ram (
    .clk  (clk),
    .we   (in_accept && s0_wr),
    .waddr(ram_waddr),
    .wdata(rx_byte),
    .re   (in_accept),
    .raddr(ram_raddr),
    .rdata(rd_data)
  );

  // Stage register between assembly and update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_r <= s1_nxt;
    end
  end

  assign s1_valid_nxt = in_accept ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_r);

  // Update stage: duplicate check, confirm counter, stray counter, offset.
  logic signed [OFFSET_W-1:0] offset_r, offset_nxt;
  logic [CONFIRM_W-1:0]       confirm_r, confirm_nxt;
  logic [STRAY_W-1:0]         stray_r, stray_nxt;
  logic                       mism_r, mism_nxt;
  logic [7:0]                 cap_r [CAP_BYTES];
  logic [7:0]                 cap_nxt [CAP_BYTES];
  logic [3*READING_W-1:0]     readings_r, readings_nxt;
  logic                       chk, mism_now, good, stray_hit, change;
  logic signed [16:0]         off_x, off_neg, off_inc;
  logic signed [18:0]         rate_sum;
  logic [NOMINAL_W-1:0]       rate;
  logic [CONFIRM_W-1:0]       confirm_dec;

  always_comb begin
    chk      = s1_r.wr && (s1_r.pos >= CHK_FIRST) && (s1_r.pos <= CHK_LAST);
    mism_now = chk && (rd_data != s1_r.rx_byte);
    mism_nxt = mism_r || mism_now;
    good     = !mism_nxt;

    // Capture reading bytes 5..9 from RAM, byte 10 from the stream.
    for (int i = 0; i < CAP_BYTES; i++) begin
      cap_nxt[i] = cap_r[i];
    end
    if (s1_r.wr && (s1_r.pos == CHK_FIRST)) begin
      cap_nxt[CAP_BYTES-1] = s1_r.rx_byte;
    end
    if (s1_r.wr && (s1_r.pos > CHK_FIRST) && (s1_r.pos <= CHK_LAST)) begin
      cap_nxt[CAP_W'(s1_r.pos - CHK_FIRST - POS_W'(1))] = rd_data;
    end

    readings_nxt = readings_r;
    confirm_nxt  = confirm_r;
    stray_nxt    = stray_r;
    offset_nxt   = offset_r;
    change       = 1'b0;
    stray_hit    = stray_r >= stray_limit_r;
    confirm_dec  = confirm_r - CONFIRM_W'(1);

    off_x   = 17'(offset_r);
    off_neg = -off_x;
    off_inc = off_neg + $signed({7'b0, step_r});

    if (s1_r.stray) begin
      if (stray_hit) begin
        offset_nxt = (offset_r > 0) ? OFFSET_W'(off_neg) : '0;
        change     = 1'b1;
        stray_nxt  = '0;
      end else begin
        stray_nxt = stray_r + STRAY_W'(1);
      end
    end

    if (s1_r.done) begin
      mism_nxt     = 1'b0;
      readings_nxt = {cap_nxt[5], cap_nxt[4], cap_nxt[3],
                      cap_nxt[2], cap_nxt[1], cap_nxt[0]};
      if (good) begin
        if (confirm_r < confirm_max_r) begin
          confirm_nxt = confirm_r + CONFIRM_W'(1);
        end
      end else begin
        if (confirm_r != '0) begin
          confirm_nxt = confirm_dec;
        end
        if (confirm_nxt == '0) begin
          if (off_x < $signed({3'b0, limit_r})) begin
            if (offset_r > 0) begin
              offset_nxt = OFFSET_W'(off_neg);
            end else if (off_inc > 17'(OFFSET_MAX)) begin
              offset_nxt = OFFSET_W'(OFFSET_MAX);
            end else begin
              offset_nxt = OFFSET_W'(off_inc);
            end
          end else begin
            offset_nxt = '0;
          end
          change = 1'b1;
        end
      end
    end

    // New rate from the updated offset, clamped to the field range.
    rate_sum = $signed({2'b0, nominal_r}) + 19'(offset_nxt);
    if (rate_sum < 0) begin
      rate = '0;
    end else if (rate_sum > 19'(RATE_MAX)) begin
      rate = NOMINAL_W'(RATE_MAX);
    end else begin
      rate = rate_sum[NOMINAL_W-1:0];
    end

    out_data_nxt = {(OUT_W - OUT_BITS)'(0),
                    readings_nxt,
                    change ? rate : NOMINAL_W'(0),
                    change,
                    s1_r.done && good,
                    s1_r.done};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r   <= '0;
      confirm_r  <= '0;
      stray_r    <= '0;
      mism_r     <= 1'b0;
      readings_r <= '0;
    end else if (s1_fire) begin
      offset_r   <= offset_nxt;
      confirm_r  <= confirm_nxt;
      stray_r    <= stray_nxt;
      mism_r     <= mism_nxt;
      readings_r <= readings_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      for (int i = 0; i < CAP_BYTES; i++) begin
        cap_r[i] <= cap_nxt[i];
      end
    end
  end

  // Output register.
  assign out_valid_nxt = s1_fire ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Checks.
  `SFSAB_ASSERT_NEXT(a_frame_swap, in_accept && s0_done,
    (byte_count_r == '0) && (write_bank_r != $past(write_bank_r)),
    "frame completion did not swap banks and clear the position")
  `SFSAB_ASSERT_NEXT(a_rd_hold, s1_valid_r && !out_free,
    $stable(rd_data), "RAM read data changed while the update stage stalled")
  `SFSAB_ASSERT_NEXT(a_stray_offset, s1_fire && s1_r.stray && stray_hit,
    offset_r <= 0, "stray limit left a positive baud offset")

endmodule

### bench/sensor_frame_sync_auto_baud_tb.sv
// ----------------------------------------------------------------------------
// sensor_frame_sync_auto_baud_tb
// Self-checking bench for the sensor frame synchroniser with baud search.
// A scoreboard predicts one result per accepted byte from its own copy of the
// frame store, counters and registers. Every result transaction is checked
// field by field. Traffic is mostly well-formed frames with random content,
// mixed with stray bytes and broken headers, under several register settings.
// ----------------------------------------------------------------------------
module sensor_frame_sync_auto_baud_tb;
  import sfsab_pkg::*;

  // Cycles the block may still need after its last result.
  localparam int SETTLE_CYCLES = 4;
  // Length of the long receiver hold-off, in cycles.
  localparam int LONG_HOLD = 300;
  // A register index beyond the five that exist.
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE = 3'd5;

  // One result transaction, unpacked.
  typedef struct packed {
    logic                 done;
    logic                 ok;
    logic                 change;
    logic [NOMINAL_W-1:0] rate;
    logic [READING_W-1:0] pm1;
    logic [READING_W-1:0] pm25;
    logic [READING_W-1:0] pm10;
  } sensor_result_t;

  // Predicts the results of the block and checks the ones it returns.
  class frame_sync_scoreboard;
    logic [7:0]           store [STORE_DEPTH];
    logic                 wr_bank;
    logic [5:0]           fill;
    int                   offset;
    logic [CONFIRM_W-1:0] confirm;
    logic [STRAY_W-1:0]   strays;
    logic [NOMINAL_W-1:0] nominal;
    logic [STEP_W-1:0]    stride;
    logic [LIMIT_W-1:0]   limit;
    logic [STRAY_W-1:0]   stray_max;
    logic [CONFIRM_W-1:0] confirm_top;
    sensor_result_t       due_results [$];
    int errors, bytes_seen, frames_done, frames_good, rate_changes, rate_clamps;

    function new();
      foreach (store[i]) store[i] = 8'h00;
      wr_bank     = 1'b0;
      fill        = '0;
      offset      = 0;
      confirm     = '0;
      strays      = '0;
      nominal     = NOMINAL_RST;
      stride      = STEP_RST;
      limit       = LIMIT_RST;
      stray_max   = STRAY_RST;
      confirm_top = CONFIRM_RST;
    endfunction

    // Mirrors a configuration write; unknown indexes are ignored.
    function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_NOMINAL_BAUD: nominal     = value[NOMINAL_W-1:0];
        REG_BAUD_STEP:    stride      = value[STEP_W-1:0];
        REG_OFFSET_LIMIT: limit       = value[LIMIT_W-1:0];
        REG_STRAY_LIMIT:  stray_max   = value[STRAY_W-1:0];
        REG_CONFIRM_MAX:  confirm_top = value[CONFIRM_W-1:0];
        default: ;
      endcase
    endfunction

    // Nominal rate plus offset, clamped to the width of the rate field.
    function logic [NOMINAL_W-1:0] line_rate();
      int sum;
      sum = int'(nominal) + offset;
      if (sum < 0) begin
        sum = 0;
        rate_clamps++;
      end else if (sum > RATE_MAX) begin
        sum = RATE_MAX;
        rate_clamps++;
      end
      return NOMINAL_W'(sum);
    endfunction

    // Works out the result of one accepted byte and queues it.
    function void absorb_byte(logic [7:0] b);
      sensor_result_t r;
      logic           fb;
      logic           good;
      int             i;
      int             grown;
      r = '0;
      bytes_seen++;

      // Frame assembly, or stray counting outside a frame.
      if (fill != 0 || b == HDR_FIRST) begin
        if (fill == 1 && b != HDR_SECOND) begin
          fill = '0;
        end else begin
          store[{wr_bank, fill[POS_W-1:0]}] = b;
          fill = fill + 6'd1;
        end
      end else if (strays >= stray_max) begin
        offset   = (offset > 0) ? -offset : 0;
        r.change = 1'b1;
        r.rate   = line_rate();
        strays   = '0;
      end else begin
        strays = strays + 8'd1;
      end

      // A complete frame swaps the banks and drives the baud search.
      if (fill >= FRAME_BYTES_DEF) begin
        wr_bank = ~wr_bank;
        fb      = ~wr_bank;
        r.done  = 1'b1;
        frames_done++;
        good = 1'b1;
        for (i = 4; i < 10; i++)
          if (store[{fb, POS_W'(i)}] != store[{fb, POS_W'(i + 6)}]) good = 1'b0;
        if (good) begin
          r.ok = 1'b1;
          frames_good++;
          if (confirm < confirm_top) confirm = confirm + 3'd1;
        end else begin
          if (confirm != 0) confirm = confirm - 3'd1;
          if (confirm == 0) begin
            if (offset < int'(limit)) begin
              if (offset > 0) begin
                offset = -offset;
              end else begin
                grown  = -offset + int'(stride);
                offset = (grown > OFFSET_MAX) ? OFFSET_MAX : grown;
              end
            end else begin
              offset = 0;
            end
            r.change = 1'b1;
            r.rate   = line_rate();
          end
        end
        fill = '0;
      end

      if (r.change) rate_changes++;
      fb     = ~wr_bank;
      r.pm1  = {store[{fb, POS_W'(6)}],  store[{fb, POS_W'(5)}]};
      r.pm25 = {store[{fb, POS_W'(8)}],  store[{fb, POS_W'(7)}]};
      r.pm10 = {store[{fb, POS_W'(10)}], store[{fb, POS_W'(9)}]};
      due_results.push_back(r);
    endfunction

    // Prints one line per mismatch, up to a cap, and counts all of them.
    task report(string msg);
      errors++;
      if (errors <= 30) $display("MISMATCH after %0d bytes: %s", bytes_seen, msg);
    endtask

    task check_field(string name, longint got, longint want);
      if (got != want) report($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    // Compares a result transaction with the oldest prediction.
    task compare_result(logic [OUT_W-1:0] d);
      sensor_result_t want;
      if (due_results.size() == 0) begin
        report("result transaction with no prediction pending");
      end else begin
        want = due_results.pop_front();
        check_field("frame_done",   d[0],     want.done);
        check_field("frame_ok",     d[1],     want.ok);
        check_field("baud_change",  d[2],     want.change);
        check_field("baud_rate",    d[19:3],  want.rate);
        check_field("pm1_reading",  d[35:20], want.pm1);
        check_field("pm25_reading", d[51:36], want.pm25);
        check_field("pm10_reading", d[67:52], want.pm10);
        check_field("padding",      d[OUT_W-1:68], 0);
      end
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_W-1:0]      out_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  frame_sync_scoreboard sb;
  int tx_idle_pct = 6;
  int rx_idle_pct = 51;
  bit long_hold_req = 1'b0;

  sensor_frame_sync_auto_baud #(
    .FRAME_BYTES(FRAME_BYTES_DEF)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [7:0] rx_byte
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [0] done, [1] ok, [2] change, [19:3] rate,
                              // [35:20] pm1, [51:36] pm25, [67:52] pm10
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // Clock: period of 10 time units.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Monitor: notes accepted bytes and checks accepted results.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.absorb_byte(in_tdata);
      if (out_tvalid && out_tready) sb.compare_result(out_tdata);
    end
  end

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        hold_left     = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // Offers one byte, with random idle cycles first, and waits for acceptance.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
  endtask

  // Stops sending and waits until every predicted result has come back.
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.due_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write; the block is idle whenever this is called.
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    sb.set_reg(idx, value);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setting(input logic [CFG_DATA_W-1:0] nom, stp, lim, str, cfm);
    cfg_reg_t             order [5];
    logic [CFG_DATA_W-1:0] vals [5];
    int i;
    order = '{REG_NOMINAL_BAUD, REG_BAUD_STEP, REG_OFFSET_LIMIT, REG_STRAY_LIMIT,
              REG_CONFIRM_MAX};
    vals  = '{nom, stp, lim, str, cfm};
    for (i = 0; i < 5; i++) write_reg(order[i], vals[i]);
  endtask

  // One whole frame that is sure to fail the duplicate check.
  task automatic send_bad_frame();
    logic [7:0] b;
    int k;
    send_byte(HDR_FIRST);
    send_byte(HDR_SECOND);
    for (k = 2; k < FRAME_BYTES_DEF; k++) begin
      b = 8'($urandom);
      if (k == 4) b = 8'h00;
      if (k == 10) b = 8'h01;
      send_byte(b);
    end
  endtask

  // Random traffic: whole frames (some passing the duplicate check), broken
  // headers and bursts of stray bytes, until n_bytes have been sent.
  task automatic send_traffic(input int n_bytes, input int good_pct, input int noise_pct);
    logic [7:0] fr [FRAME_BYTES_DEF];
    logic [7:0] fixed;
    int sent, k, len;
    sent = 0;
    while (sent < n_bytes) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        if ($urandom_range(0, 1) == 1) begin
          // Header whose second byte is wrong.
          fr[1] = 8'($urandom);
          if (fr[1] == HDR_SECOND) fr[1] = fr[1] ^ 8'h01;
          send_byte(HDR_FIRST);
          send_byte(fr[1]);
          sent += 2;
        end else begin
          len = $urandom_range(1, 8);
          for (k = 0; k < len; k++) send_byte(8'($urandom));
          sent += len;
        end
      end else begin
        fr[0] = HDR_FIRST;
        fr[1] = HDR_SECOND;
        for (k = 2; k < FRAME_BYTES_DEF; k++) fr[k] = 8'($urandom);
        // Now and then push the reading bytes to their extremes.
        if ($urandom_range(0, 4) == 0) begin
          fixed = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
          for (k = 5; k < 11; k++) fr[k] = fixed;
        end
        if ($urandom_range(0, 99) < good_pct)
          for (k = 4; k < 10; k++) fr[k + 6] = fr[k];
        for (k = 0; k < FRAME_BYTES_DEF; k++) send_byte(fr[k]);
        sent += FRAME_BYTES_DEF;
      end
    end
  endtask

  // Main sequence.
  initial begin
    logic [7:0] opening [9];
    int n;
    opening = '{8'h00, 8'hFF, HDR_FIRST, 8'h00, HDR_FIRST, HDR_FIRST, HDR_SECOND,
                8'hAA, 8'h55};
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: strays at the byte extremes, broken headers, a lone second
    // header byte, then a zero and a unit stray limit and a write to an
    // index that does not exist.
    foreach (opening[i]) send_byte(opening[i]);
    settle();
    write_reg(REG_STRAY_LIMIT, '0);
    send_byte(8'h00);
    send_byte(8'h7F);
    settle();
    write_reg(REG_SPARE, '1);
    write_reg(REG_STRAY_LIMIT, CFG_DATA_W'(1));
    send_byte(8'h01);
    send_byte(8'h80);
    send_byte(8'hFE);
    send_byte(8'h01);

    // Widest step and limit with the confirm maximum at zero. A bad frame
    // followed by one stray byte grows the offset by a whole step, so it
    // reaches its saturation value; two bad frames in a row then clear it to zero.
    settle();
    apply_setting(CFG_DATA_W'(115200), CFG_DATA_W'(1023), CFG_DATA_W'(16383), '0, '0);
    for (n = 0; n < 17; n++) begin
      send_bad_frame();
      send_byte(8'h00);
    end
    send_bad_frame();
    send_bad_frame();

    // Low nominal rate and wide steps, so the rate clamps at zero. The
    // receiver holds off for a long stretch, and the sender pauses once.
    settle();
    apply_setting(CFG_DATA_W'(1200), CFG_DATA_W'(1000), CFG_DATA_W'(9600),
                  CFG_DATA_W'(1), CFG_DATA_W'(1));
    send_traffic(80, 40, 20);
    long_hold_req = 1'b1;
    send_traffic(80, 40, 20);
    settle();
    send_traffic(40, 40, 20);

    // Sender idles more than the receiver; rate at the top of its range.
    tx_idle_pct = 51;
    rx_idle_pct = 6;
    settle();
    apply_setting(CFG_DATA_W'(131071), CFG_DATA_W'(1), CFG_DATA_W'(100), '0,
                  CFG_DATA_W'(7));
    send_traffic(100, 70, 30);

    // No idling; random settings, the confirm maximum usually lowered.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    for (n = 0; n < 2; n++) begin
      settle();
      apply_setting(CFG_DATA_W'($urandom_range(0, 131071)),
                    CFG_DATA_W'($urandom_range(0, 1023)),
                    CFG_DATA_W'($urandom_range(0, 16383)),
                    CFG_DATA_W'($urandom_range(0, 15)),
                    CFG_DATA_W'($urandom_range(0, 7)));
      send_traffic(40, 50, 20);
    end

    settle();
    $display("Covered %0d bytes, %0d frames (%0d passing the duplicate check),",
             sb.bytes_seen, sb.frames_done, sb.frames_good);
    $display("%0d baud changes (%0d clamped) and %0d mismatches.",
             sb.rate_changes, sb.rate_clamps, sb.errors);
    if (sb.errors == 0) begin
      $display("sensor_frame_sync_auto_baud_tb: done, clean");
    end else begin
      $display("sensor_frame_sync_auto_baud_tb: done, errors");
    end
    $finish;
  end

  // Watchdog: the run should end long before this.
  initial begin
    #4000000;
    $display("sensor_frame_sync_auto_baud_tb: done, errors");
    $finish;
  end

endmodule
